// ===== src/owbm_pkg.sv =====
// ----------------------------------------------------------------------------
// owbm_pkg - shared types and constants for the single-wire bus master
// Register indexes, reset values, field widths and the packed result record.
// ----------------------------------------------------------------------------
package owbm_pkg;

    // field widths
    localparam int unsigned CMD_W      = 2;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned TICK_W     = 10;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 10;
    localparam int unsigned IN_TDATA_W  = 16;
    localparam int unsigned OUT_TDATA_W = 16;

    // command codes
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RESET = 2'd1;
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRES_DELAY = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RECOVERY   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_START = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT       = 3'd4;

    // register reset values
    localparam logic [9:0] RST_RESET_LOW  = 10'd480;
    localparam logic [7:0] RST_PRES_DELAY = 8'd30;
    localparam logic [9:0] RST_RECOVERY   = 10'd200;
    localparam logic [3:0] RST_SLOT_START = 4'd2;
    localparam logic [7:0] RST_SLOT       = 8'd45;

    typedef struct packed {
        logic [9:0] reset_low_ticks;
        logic [7:0] presence_delay_ticks;
        logic [9:0] reset_recovery_ticks;
        logic [3:0] slot_start_ticks;
        logic [7:0] slot_ticks;
    } t_cfg;

    // drive_low sits in bit 0
    typedef struct packed {
        logic [BYTE_W-1:0] rx_byte;
        logic              presence_bit;
        logic              done_res;
        logic              busy_res;
        logic              drive_low;
    } t_result;

endpackage

// ===== src/owbm_cfg.sv =====
// ----------------------------------------------------------------------------
// owbm_cfg - timing register bank
// Write-only registers, masked to their widths, reset to the standard timings.
// ----------------------------------------------------------------------------
module owbm_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [owbm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [owbm_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output owbm_pkg::t_cfg                  o_cfg
);
    import owbm_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reset_low_ticks      <= RST_RESET_LOW;
            r_cfg.presence_delay_ticks <= RST_PRES_DELAY;
            r_cfg.reset_recovery_ticks <= RST_RECOVERY;
            r_cfg.slot_start_ticks     <= RST_SLOT_START;
            r_cfg.slot_ticks           <= RST_SLOT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_RESET_LOW:  r_cfg.reset_low_ticks      <= i_cfg_wdata[9:0];
                CFG_PRES_DELAY: r_cfg.presence_delay_ticks <= i_cfg_wdata[7:0];
                CFG_RECOVERY:   r_cfg.reset_recovery_ticks <= i_cfg_wdata[9:0];
                CFG_SLOT_START: r_cfg.slot_start_ticks     <= i_cfg_wdata[3:0];
                CFG_SLOT:       r_cfg.slot_ticks           <= i_cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== src/owbm_ctrl.sv =====
// ----------------------------------------------------------------------------
// owbm_ctrl - bus sequencer
// Phase, tick counter and shifters; one tick processed per transaction.
// ----------------------------------------------------------------------------
module owbm_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  owbm_pkg::t_cfg              i_cfg,
    input  logic                        i_tick,
    input  logic [owbm_pkg::CMD_W-1:0]  i_command,
    input  logic [owbm_pkg::BYTE_W-1:0] i_tx_byte,
    input  logic                        i_line_level,
    output owbm_pkg::t_result           o_result
);
    import owbm_pkg::*;

    localparam logic [2:0] PH_IDLE     = 3'd0;
    localparam logic [2:0] PH_RST_LOW  = 3'd1;
    localparam logic [2:0] PH_RST_WAIT = 3'd2;
    localparam logic [2:0] PH_RST_REC  = 3'd3;
    localparam logic [2:0] PH_WR_LOW   = 3'd4;
    localparam logic [2:0] PH_WR_DATA  = 3'd5;
    localparam logic [2:0] PH_RD_LOW   = 3'd6;
    localparam logic [2:0] PH_RD_DATA  = 3'd7;

    logic [2:0]        r_phase,      n_phase;
    logic [TICK_W-1:0] r_tick_count, n_tick_count;
    logic [2:0]        r_bit_index,  n_bit_index;
    logic [BYTE_W-1:0] r_shift_out,  n_shift_out;
    logic [BYTE_W-1:0] r_shift_in,   n_shift_in;
    logic              r_presence,   n_presence;
    t_result           n_result;

    always_comb begin
        logic [2:0]        ph;
        logic [TICK_W-1:0] tc;
        logic [TICK_W-1:0] len;
        logic              is_last;

        ph           = r_phase;
        tc           = r_tick_count;
        n_bit_index  = r_bit_index;
        n_shift_out  = r_shift_out;
        n_shift_in   = r_shift_in;
        n_presence   = r_presence;
        n_result     = '0;
        len          = '0;
        is_last      = 1'b0;

        // command taken only on an idle tick; that tick already belongs to it
        if (r_phase == PH_IDLE && i_command != CMD_TICK) begin
            tc          = '0;
            n_bit_index = '0;
            case (i_command)
                CMD_RESET: ph = PH_RST_LOW;
                CMD_WRITE: begin
                    ph          = PH_WR_LOW;
                    n_shift_out = i_tx_byte;
                end
                default: begin
                    ph         = PH_RD_LOW;
                    n_shift_in = '0;
                end
            endcase
        end

        n_phase      = ph;
        n_tick_count = tc;

        if (ph != PH_IDLE) begin
            n_result.busy_res = 1'b1;
            case (ph)
                PH_RST_LOW, PH_WR_LOW, PH_RD_LOW: n_result.drive_low = 1'b1;
                PH_RST_REC: if (tc == '0) n_presence = i_line_level;
                PH_WR_DATA: n_result.drive_low = ~n_shift_out[n_bit_index];
                PH_RD_DATA: if (tc == '0) n_shift_in[n_bit_index] = i_line_level;
                default: ;
            endcase

            // zero in a length register acts as one tick
            case (ph)
                PH_RST_LOW:  len = i_cfg.reset_low_ticks;
                PH_RST_WAIT: len = {2'b00, i_cfg.presence_delay_ticks};
                PH_RST_REC:  len = i_cfg.reset_recovery_ticks;
                PH_WR_LOW, PH_RD_LOW: len = {6'b000000, i_cfg.slot_start_ticks};
                default:     len = {2'b00, i_cfg.slot_ticks};
            endcase
            if (len == '0) len = TICK_W'(1);

            n_tick_count = tc + TICK_W'(1);
            is_last      = (n_tick_count >= len);

            if (is_last) begin
                n_tick_count = '0;
                case (ph)
                    PH_RST_LOW:  n_phase = PH_RST_WAIT;
                    PH_RST_WAIT: n_phase = PH_RST_REC;
                    PH_RST_REC: begin
                        n_phase           = PH_IDLE;
                        n_result.done_res = 1'b1;
                    end
                    PH_WR_LOW:   n_phase = PH_WR_DATA;
                    PH_RD_LOW:   n_phase = PH_RD_DATA;
                    default: begin
                        if (n_bit_index == 3'd7) begin
                            n_phase           = PH_IDLE;
                            n_result.done_res = 1'b1;
                        end else begin
                            n_bit_index = n_bit_index + 3'd1;
                            n_phase     = (ph == PH_WR_DATA) ? PH_WR_LOW : PH_RD_LOW;
                        end
                    end
                endcase
            end
        end

        n_result.presence_bit = n_presence;
        n_result.rx_byte      = n_shift_in;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_tick_count <= '0;
            r_bit_index  <= '0;
            r_shift_out  <= '0;
            r_shift_in   <= '0;
            r_presence   <= 1'b1;
        end else if (i_tick) begin
            r_phase      <= n_phase;
            r_tick_count <= n_tick_count;
            r_bit_index  <= n_bit_index;
            r_shift_out  <= n_shift_out;
            r_shift_in   <= n_shift_in;
            r_presence   <= n_presence;
        end
    end

    assign o_result = n_result;

`ifndef NO_ASSERTIONS
    a_done_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_tick && n_result.done_res) |=> (r_phase == PH_IDLE))
        else $error("operation finished but sequencer not idle");

    a_drive_only_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_tick && n_result.drive_low) |-> n_result.busy_res)
        else $error("bus driven outside an operation");

    a_idle_count_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> (r_tick_count == '0))
        else $error("tick counter not cleared while idle");
`endif

endmodule

// ===== src/owbm_skid.sv =====
// ----------------------------------------------------------------------------
// owbm_skid - two-entry result buffer
// Holds results so the input side keeps flowing while the output stalls, until both entries are full.
// ----------------------------------------------------------------------------
module owbm_skid (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  owbm_pkg::t_result i_result,
    output logic              o_ready,
    output logic              o_valid,
    input  logic              i_pop_ready,
    output owbm_pkg::t_result o_result
);
    import owbm_pkg::*;

    t_result    r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count, n_count;
    logic       pop;

    assign o_ready  = (r_count != 2'd2);
    assign o_valid  = (r_count != 2'd0);
    assign pop      = o_valid && i_pop_ready;
    assign o_result = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !pop)      n_count = r_count + 2'd1;
        else if (!i_push && pop) n_count = r_count - 2'd1;
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_result;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= ~r_wr_ptr;
            if (pop)    r_rd_ptr <= ~r_rd_ptr;
            r_count <= n_count;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("result buffer over-filled");

    a_push_only_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> o_ready)
        else $error("result written into a full buffer");

    a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd1) |-> (r_wr_ptr != r_rd_ptr))
        else $error("pointers disagree with fill count");
`endif

endmodule

// ===== src/one_wire_bus_master_unit.sv =====
// ----------------------------------------------------------------------------
// one_wire_bus_master_unit - single-wire bus master, one tick per transaction
// Reset/presence, byte write and byte read sequences on a sampled bus line.
// ----------------------------------------------------------------------------
//
//  channel  | dir | contents
//  ---------+-----+-------------------------------------------------------
//  s_axis   | in  | one microsecond tick: command, tx byte, line level
//  m_axis   | out | one result per tick: drive, busy, done, presence, rx
//  i_cfg_*  | in  | timing register writes, no read-back
//
//  Each input transaction is processed in the cycle it is taken: the
//  sequencer state updates at that edge and the result enters a two-entry
//  buffer, so one tick per clock is sustained while m_axis takes results;
//  the result is registered in the buffer before it appears on m_axis.
//  s_axis_tready depends only on the buffer fill, not on m_axis_tready; it
//  drops only after two results wait untaken.
//  Synchronous active-low reset: idle, counters clear, presence reads 1,
//  timings at their standard values.
//
module one_wire_bus_master_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [1:0] command, [9:2] tx_byte, [10] line_level, [15:11] zero
    input  logic [owbm_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [0] drive_low, [1] busy_res, [2] done_res, [3] presence_bit,
    // [11:4] rx_byte, [15:12] zero
    output logic [owbm_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                             i_cfg_we,
    input  logic [owbm_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [owbm_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);
    import owbm_pkg::*;

    t_cfg    cfg;
    t_result tick_result;
    t_result buf_result;
    logic    tick_acc;

    // a tick moves the sequencer only when the result has somewhere to go
    assign tick_acc = s_axis_tvalid && s_axis_tready;

    owbm_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    owbm_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_tick       (tick_acc),
        .i_command    (s_axis_tdata[1:0]),
        .i_tx_byte    (s_axis_tdata[9:2]),
        .i_line_level (s_axis_tdata[10]),
        .o_result     (tick_result)
    );

    owbm_skid u_skid (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (tick_acc),
        .i_result    (tick_result),
        .o_ready     (s_axis_tready),
        .o_valid     (m_axis_tvalid),
        .i_pop_ready (m_axis_tready),
        .o_result    (buf_result)
    );

    assign m_axis_tdata = {4'b0000, buf_result};

endmodule
